FILE: hdl/inpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inpr_pkg: IPv4 nearest-prefix route table package
// Shared payload types, opcodes, widths and the leading-match count function.
// ----------------------------------------------------------------------------
package inpr_pkg;

    localparam int ADDR_W  = 32;
    localparam int ADP_W   = 8;
    localparam int LEN_W   = 6;
    localparam int ENTRY_W = ADDR_W + ADP_W;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] address;
        logic [ADP_W-1:0]  adapter_number;
    } inpr_req_t;

    typedef struct packed {
        logic              found;
        logic [ADP_W-1:0]  best_adapter;
        logic [LEN_W-1:0]  match_length;
        logic              table_full;
    } inpr_rsp_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } inpr_cmd_t;

    function automatic logic [3:0] lead_zero8(input logic [7:0] b);
        logic [3:0] n;
        logic       done;
        int         i;
        n    = 4'd0;
        done = 1'b0;
        for (i = 7; i >= 0; i--)
        begin
            if (!done)
            begin
                if (b[i])
                    done = 1'b1;
                else
                    n = n + 4'd1;
            end
        end
        return n;
    endfunction

    // Leading zeros of the xor of two addresses = shared leading bits.
    function automatic logic [LEN_W-1:0] shared_lead(input logic [ADDR_W-1:0] diff);
        logic [LEN_W-1:0] n;
        if (diff[31:24] != 8'd0)
            n = {2'b00, lead_zero8(diff[31:24])};
        else if (diff[23:16] != 8'd0)
            n = 6'd8 + {2'b00, lead_zero8(diff[23:16])};
        else if (diff[15:8] != 8'd0)
            n = 6'd16 + {2'b00, lead_zero8(diff[15:8])};
        else if (diff[7:0] != 8'd0)
            n = 6'd24 + {2'b00, lead_zero8(diff[7:0])};
        else
            n = 6'd32;
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/inpr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inpr_if: request and response channel interfaces
// Valid/ready channels carrying route items and results.
// ----------------------------------------------------------------------------
interface inpr_req_if;
    import inpr_pkg::*;

    logic      valid;
    logic      ready;
    inpr_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface inpr_rsp_if;
    import inpr_pkg::*;

    logic      valid;
    logic      ready;
    inpr_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/inpr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inpr_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle.
// ----------------------------------------------------------------------------
module inpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: hdl/inpr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inpr_ctrl: route table controller
// Accepts an item, sweeps the table indices, waits out the compare pipeline
// and commits the result once the output register is free.
// ----------------------------------------------------------------------------
module inpr_ctrl #(
    parameter int ROUTE_ENTRIES = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire logic                             out_busy,
    output inpr_pkg::inpr_cmd_t                   cmd,
    output logic [$clog2(ROUTE_ENTRIES)-1:0]      scan_idx
);
    import inpr_pkg::*;

    localparam int IDX_W = $clog2(ROUTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN1 = 3'd2;
    localparam logic [2:0] ST_DRAIN2 = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (idx_reg == LAST_IDX)
                    state_next = ST_DRAIN1;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_DRAIN1:
                state_next = ST_DRAIN2;
            ST_DRAIN2:
                state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (!out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign scan_idx = idx_reg;

endmodule
`default_nettype wire

FILE: hdl/inpr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inpr_dp: route table datapath
// Route RAM, valid bits, two-stage per-entry compare pipeline, best/hit/free
// trackers and the result register.
// ----------------------------------------------------------------------------
module inpr_dp #(
    parameter int ROUTE_ENTRIES = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire inpr_pkg::inpr_cmd_t              cmd,
    input  wire logic [$clog2(ROUTE_ENTRIES)-1:0] scan_idx,
    input  wire inpr_pkg::inpr_req_t              req_data,
    output logic                                  rsp_valid,
    output inpr_pkg::inpr_rsp_t                   rsp_data,
    input  wire logic                             rsp_ready,
    output logic                                  out_busy
);
    import inpr_pkg::*;

    localparam int IDX_W = $clog2(ROUTE_ENTRIES);

    inpr_req_t           key_reg;
    logic [ROUTE_ENTRIES-1:0] valid_reg;

    logic [ENTRY_W-1:0]  ram_rdata;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;

    logic                p1_valid_reg;
    logic [IDX_W-1:0]    p1_idx_reg;

    logic                p2_valid_reg;
    logic [IDX_W-1:0]    p2_idx_reg;
    logic                p2_vbit_reg;
    logic [LEN_W-1:0]    p2_len_reg;
    logic [ADDR_W-1:0]   p2_addr_reg;
    logic [ADP_W-1:0]    p2_adp_reg;

    logic [LEN_W-1:0]    best_len_reg;
    logic [ADDR_W-1:0]   best_addr_reg;
    logic [ADP_W-1:0]    best_adp_reg;
    logic                hit_found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;

    logic                rsp_valid_reg;
    inpr_rsp_t           rsp_data_reg;
    inpr_rsp_t           result;

    inpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROUTE_ENTRIES)
    ) u_route_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({key_reg.address, key_reg.adapter_number}),
        .re    (cmd.issue),
        .raddr (scan_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            key_reg <= req_data;
    end

    // compare pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg  <= scan_idx;
        p2_idx_reg  <= p1_idx_reg;
        p2_vbit_reg <= valid_reg[p1_idx_reg];
        p2_len_reg  <= shared_lead(ram_rdata[ENTRY_W-1:ADP_W] ^ key_reg.address);
        p2_addr_reg <= ram_rdata[ENTRY_W-1:ADP_W];
        p2_adp_reg  <= ram_rdata[ADP_W-1:0];
    end

    // trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_len_reg   <= '0;
            best_addr_reg  <= '0;
            best_adp_reg   <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else if (cmd.load)
        begin
            best_len_reg   <= '0;
            best_addr_reg  <= '0;
            best_adp_reg   <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (p2_valid_reg)
        begin
            if (key_reg.opcode == OP_LOOKUP)
            begin
                if (p2_vbit_reg && (p2_len_reg != '0) &&
                    ((p2_len_reg > best_len_reg) ||
                     ((p2_len_reg == best_len_reg) && (p2_addr_reg < best_addr_reg))))
                begin
                    best_len_reg  <= p2_len_reg;
                    best_addr_reg <= p2_addr_reg;
                    best_adp_reg  <= p2_adp_reg;
                end
            end
            else
            begin
                if (p2_vbit_reg)
                begin
                    if (!hit_found_reg && (p2_addr_reg == key_reg.address))
                    begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= p2_idx_reg;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= p2_idx_reg;
                end
            end
        end
    end

    // commit: table write and result
    always_comb
    begin
        result    = '0;
        ram_we    = 1'b0;
        ram_waddr = hit_idx_reg;
        if (key_reg.opcode == OP_LOOKUP)
        begin
            result.found        = (best_len_reg != '0);
            result.best_adapter = best_adp_reg;
            result.match_length = best_len_reg;
        end
        else
        begin
            priority if (hit_found_reg)
            begin
                ram_we    = cmd.commit;
                ram_waddr = hit_idx_reg;
            end
            else if (free_found_reg)
            begin
                ram_we    = cmd.commit;
                ram_waddr = free_idx_reg;
            end
            else
            begin
                result.table_full = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ram_we)
            valid_reg[ram_waddr] <= 1'b1;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.commit)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            rsp_data_reg <= result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign out_busy  = rsp_valid_reg && !rsp_ready;

endmodule
`default_nettype wire

FILE: hdl/ipv4_nearest_prefix_route_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_nearest_prefix_route_top: IPv4 nearest-prefix route table
// Route add/overwrite and longest-leading-match lookup over ROUTE_ENTRIES
// routes, one result per request transaction.
// ----------------------------------------------------------------------------
// The table sits in one RAM that is read one entry per cycle. The read is
// followed by a two-stage compare pipeline and a commit cycle that writes the
// table and loads the result register. A new request is accepted in the cycle
// after the previous one has committed, even while its result still waits in
// the output register. Commit stalls only while that register is occupied and
// not being drained. Ties between equal match lengths go to the smallest stored
// address, and an add of a new address with no free entry returns table_full.
// No clearing pass is needed after reset.
module ipv4_nearest_prefix_route_top #(
    parameter int ROUTE_ENTRIES = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    inpr_req_if.sink    req,
    inpr_rsp_if.source  rsp
);
    import inpr_pkg::*;

    localparam int IDX_W = $clog2(ROUTE_ENTRIES);

    inpr_cmd_t        cmd;
    logic [IDX_W-1:0] scan_idx;
    logic             out_busy;

    inpr_ctrl #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .out_busy  (out_busy),
        .cmd       (cmd),
        .scan_idx  (scan_idx)
    );

    inpr_dp #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .scan_idx  (scan_idx),
        .req_data  (req.data),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data),
        .rsp_ready (rsp.ready),
        .out_busy  (out_busy)
    );

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !out_busy)
        else $error("commit while result register occupied");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("committed result not presented");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second request accepted while one in flight");

    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.found) |->
            (rsp.data.match_length != '0) && !rsp.data.table_full)
        else $error("found result with zero length or full flag");

endmodule
`default_nettype wire
